// ===== src/sla_pkg.sv =====
// shared constants, payload types and state encoding of the skyline atlas allocator
package sla_pkg;

   localparam int PAGE_COLUMNS = 256;
   localparam int PAGE_ROWS    = 256;

   localparam int COL_W   = $clog2(PAGE_COLUMNS);
   localparam int HGT_W   = $clog2(PAGE_ROWS + 1);
   localparam int CNT_W   = COL_W + 1;
   localparam int FIELD_W = 9;
   localparam int POS_W   = 8;

   typedef logic [COL_W-1:0] col_type;
   typedef logic [HGT_W-1:0] hgt_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [FIELD_W-1:0] width;
      logic [FIELD_W-1:0] height;
   } req_type;

   typedef struct packed {
      logic             found;
      logic             page;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FWD,
      ST_BWD,
      ST_FILL
   } state_type;

   function automatic hgt_type hgt_max(input hgt_type a, input hgt_type b);
      hgt_max = (a > b) ? a : b;
   endfunction

endpackage

// ===== src/sla_ram.sv =====
// column store: one write port, one read port with registered read data
module sla_ram (
   input  logic             clock,
   input  logic             wr_en,
   input  sla_pkg::col_type wr_addr,
   input  sla_pkg::hgt_type wr_data,
   input  logic             rd_en,
   input  sla_pkg::col_type rd_addr,
   output sla_pkg::hgt_type rd_data
);

   sla_pkg::hgt_type mem [sla_pkg::PAGE_COLUMNS];
   sla_pkg::hgt_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/skyline_atlas_allocator.sv =====
// top level of the skyline bottom-left atlas allocator
//
//   channel   ports                      handshake
//   ------    -------------------------  -----------------------------------------
//   request   start, busy, req_item      item taken at an edge with start & !busy
//   result    rsp_strobe, rsp_item       one cycle per item, no back-pressure
//
// flow: a rejected item (zero size, too wide) answers in the cycle after it is taken;
//   otherwise a forward pass and a backward pass sweep all columns, then a fill pass
//   raises the covered columns when the item fits; the result strobe follows the last pass
// the two sweeps run over the column store's single read port
// reset: a clearing pass writes zero to all 256 columns (busy high)
// the receiver cannot stall: each result is shown for exactly one cycle
module skyline_atlas_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sla_pkg::req_type req_item,
   output logic             rsp_strobe,
   output sla_pkg::rsp_type rsp_item
);

   localparam sla_pkg::cnt_type CNT_END  = sla_pkg::CNT_W'(sla_pkg::PAGE_COLUMNS);
   localparam sla_pkg::cnt_type CNT_LAST = sla_pkg::CNT_W'(sla_pkg::PAGE_COLUMNS - 1);
   localparam sla_pkg::col_type COL_MAX  = sla_pkg::COL_W'(sla_pkg::PAGE_COLUMNS - 1);
   localparam sla_pkg::hgt_type ROWS     = sla_pkg::HGT_W'(sla_pkg::PAGE_ROWS);

   // control and pipeline registers
   sla_pkg::state_type state_ff, state_in;
   sla_pkg::cnt_type   k_ff, k_in;           // sweep / fill counter
   logic               rd_v_ff, rd_v_in;     // read issued last cycle
   sla_pkg::col_type   addr_d1_ff, addr_d1_in;
   logic               win_d1_ff, win_d1_in; // window at addr_d1 fits the page
   logic               rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   logic [sla_pkg::FIELD_W-1:0] width_ff, width_in;
   logic [sla_pkg::FIELD_W-1:0] height_ff, height_in;
   sla_pkg::col_type   ph_ff, ph_in;         // position inside a block of width columns
   sla_pkg::hgt_type   run_ff, run_in;       // running prefix / suffix max
   sla_pkg::hgt_type   best_ff, best_in;
   sla_pkg::col_type   best_x_ff, best_x_in;
   sla_pkg::rsp_type   rsp_ff, rsp_in;

   // column height store
   logic             h_we, h_re;
   sla_pkg::col_type h_wa, h_ra;
   sla_pkg::hgt_type h_wd, h_rd;

   // block prefix max scratch
   logic             s_we, s_re;
   sla_pkg::col_type s_wa, s_ra;
   sla_pkg::hgt_type s_wd, s_rd;

   // datapath helpers
   logic             req_ok;
   sla_pkg::col_type wm1;
   sla_pkg::col_type rev_addr;
   sla_pkg::cnt_type end_addr;
   logic             restart;
   sla_pkg::hgt_type run_new;
   sla_pkg::hgt_type win_max;
   logic             take;
   sla_pkg::hgt_type best_new;
   sla_pkg::col_type best_x_new;
   logic             fits;
   sla_pkg::rsp_type rsp_fail;

   sla_ram u_heights (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_wa),
      .wr_data (h_wd),
      .rd_en   (h_re),
      .rd_addr (h_ra),
      .rd_data (h_rd)
   );

   sla_ram u_prefix (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_wa),
      .wr_data (s_wd),
      .rd_en   (s_re),
      .rd_addr (s_ra),
      .rd_data (s_rd)
   );

   // request checks and sweep arithmetic
   assign req_ok = (req_item.width != '0) && (req_item.height != '0) &&
                   (req_item.width <= sla_pkg::FIELD_W'(sla_pkg::PAGE_COLUMNS));
   assign wm1      = sla_pkg::col_type'(width_ff[sla_pkg::COL_W-1:0] - 1'b1);
   assign rev_addr = ~k_ff[sla_pkg::COL_W-1:0];
   // last column of the window starting at rev_addr; bit above the index means off page
   assign end_addr = sla_pkg::CNT_W'({1'b0, rev_addr}) + sla_pkg::CNT_W'(width_ff)
                     - sla_pkg::CNT_W'(1);

   // forward pass restarts at each block start, backward pass at each block end
   assign restart = (state_ff == sla_pkg::ST_FWD) ? (ph_ff == '0)
                                                  : ((ph_ff == wm1) || (addr_d1_ff == COL_MAX));
   assign run_new = restart ? h_rd : sla_pkg::hgt_max(run_ff, h_rd);
   // window max = max of the suffix max of its first block part and the prefix max of its second part
   assign win_max = sla_pkg::hgt_max(run_new, s_rd);
   // backward sweep: ties replace, so the leftmost minimum survives
   assign take       = rd_v_ff && win_d1_ff && (win_max <= best_ff);
   assign best_new   = take ? win_max : best_ff;
   assign best_x_new = take ? addr_d1_ff : best_x_ff;
   assign fits = ({1'b0, best_new} + (sla_pkg::HGT_W + 1)'(height_ff))
                 <= (sla_pkg::HGT_W + 1)'(sla_pkg::PAGE_ROWS);

   assign rsp_fail = '{found: 1'b0, page: 1'b0, pos_x: '0, pos_y: '0};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sla_pkg::ST_CLEAR: begin
            if (k_ff == CNT_LAST) begin
               state_in = sla_pkg::ST_IDLE;
            end
         end
         sla_pkg::ST_IDLE: begin
            if (start && req_ok) begin
               state_in = sla_pkg::ST_FWD;
            end
         end
         sla_pkg::ST_FWD: begin
            if (k_ff == CNT_END) begin
               state_in = sla_pkg::ST_BWD;
            end
         end
         sla_pkg::ST_BWD: begin
            if (k_ff == CNT_END) begin
               state_in = fits ? sla_pkg::ST_FILL : sla_pkg::ST_IDLE;
            end
         end
         sla_pkg::ST_FILL: begin
            if (k_ff == sla_pkg::CNT_W'(width_ff - 1'b1)) begin
               state_in = sla_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sla_pkg::ST_IDLE;
         end
      endcase
   end

   // memory controls and datapath per state
   always_comb begin
      h_we = 1'b0;  h_wa = '0;  h_wd = '0;  h_re = 1'b0;  h_ra = '0;
      s_we = 1'b0;  s_wa = '0;  s_wd = '0;  s_re = 1'b0;  s_ra = '0;
      k_in          = k_ff;
      rd_v_in       = 1'b0;
      addr_d1_in    = addr_d1_ff;
      win_d1_in     = 1'b0;
      width_in      = width_ff;
      height_in     = height_ff;
      ph_in         = ph_ff;
      run_in        = run_ff;
      best_in       = best_ff;
      best_x_in     = best_x_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      busy          = 1'b1;
      case (state_ff)
         sla_pkg::ST_CLEAR: begin
            h_we = 1'b1;
            h_wa = k_ff[sla_pkg::COL_W-1:0];
            k_in = (k_ff == CNT_LAST) ? '0 : k_ff + 1'b1;
         end
         sla_pkg::ST_IDLE: begin
            busy = 1'b0;
            k_in = '0;
            if (start) begin
               if (req_ok) begin
                  width_in  = req_item.width;
                  height_in = req_item.height;
                  ph_in     = '0;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = rsp_fail;
               end
            end
         end
         sla_pkg::ST_FWD: begin
            // read column k, fold column k-1 into the block prefix max
            if (!k_ff[sla_pkg::COL_W]) begin
               h_re       = 1'b1;
               h_ra       = k_ff[sla_pkg::COL_W-1:0];
               rd_v_in    = 1'b1;
               addr_d1_in = k_ff[sla_pkg::COL_W-1:0];
            end
            if (rd_v_ff) begin
               s_we   = 1'b1;
               s_wa   = addr_d1_ff;
               s_wd   = run_new;
               run_in = run_new;
               ph_in  = (ph_ff == wm1) ? '0 : ph_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == CNT_END) begin
               // hand the phase of the last column to the backward pass
               k_in      = '0;
               ph_in     = ph_ff;
               best_in   = ROWS;
               best_x_in = '0;
            end
         end
         sla_pkg::ST_BWD: begin
            // columns right to left: suffix max here, prefix max at window end
            if (!k_ff[sla_pkg::COL_W]) begin
               h_re       = 1'b1;
               h_ra       = rev_addr;
               s_re       = !end_addr[sla_pkg::COL_W];
               s_ra       = end_addr[sla_pkg::COL_W-1:0];
               rd_v_in    = 1'b1;
               addr_d1_in = rev_addr;
               win_d1_in  = !end_addr[sla_pkg::COL_W];
            end
            if (rd_v_ff) begin
               run_in = run_new;
               ph_in  = (ph_ff == '0) ? wm1 : ph_ff - 1'b1;
            end
            best_in   = best_new;
            best_x_in = best_x_new;
            k_in      = k_ff + 1'b1;
            if (k_ff == CNT_END) begin
               k_in = '0;
               if (!fits) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = rsp_fail;
               end
            end
         end
         sla_pkg::ST_FILL: begin
            // raise the covered columns one per cycle
            h_we = 1'b1;
            h_wa = best_x_ff + k_ff[sla_pkg::COL_W-1:0];
            h_wd = sla_pkg::HGT_W'(best_ff + sla_pkg::HGT_W'(height_ff));
            k_in = k_ff + 1'b1;
            if (k_ff == sla_pkg::CNT_W'(width_ff - 1'b1)) begin
               k_in          = '0;
               rsp_strobe_in = 1'b1;
               rsp_in        = '{found: 1'b1, page: 1'b0,
                                 pos_x: sla_pkg::POS_W'(best_x_ff),
                                 pos_y: sla_pkg::POS_W'(best_ff)};
            end
         end
         default: begin
            k_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sla_pkg::ST_CLEAR;
         k_ff          <= '0;
         rd_v_ff       <= 1'b0;
         win_d1_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         rd_v_ff       <= rd_v_in;
         win_d1_ff     <= win_d1_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_d1_ff <= addr_d1_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      ph_ff      <= ph_in;
      run_ff     <= run_in;
      best_ff    <= best_in;
      best_x_ff  <= best_x_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== src/sla_checker.sv =====
// port-level checks of the allocator, bound to the top level
module sla_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input sla_pkg::req_type req_item,
   input logic             rsp_strobe,
   input sla_pkg::rsp_type rsp_item
);

   logic take_bad;
   logic take_good;

   assign take_bad  = start && !busy &&
                      ((req_item.width == '0) || (req_item.height == '0) ||
                       (req_item.width > sla_pkg::FIELD_W'(sla_pkg::PAGE_COLUMNS)));
   assign take_good = start && !busy && !take_bad;

   // reset starts the clearing pass with no result
   a_reset_quiet: assert property (@(posedge clock) reset |=> busy && !rsp_strobe)
      else $error("result or idle right after reset");

   // a failed placement carries all-zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.found |->
         (!rsp_item.page && (rsp_item.pos_x == '0) && (rsp_item.pos_y == '0)))
      else $error("failed item with nonzero fields");

   // an impossible request is answered at once with a failure
   a_bad_fast: assert property (@(posedge clock) disable iff (reset)
      take_bad |=> rsp_strobe && !rsp_item.found)
      else $error("bad item not rejected next cycle");

   // a real request goes busy and gives no result in the next cycle
   a_good_busy: assert property (@(posedge clock) disable iff (reset)
      take_good |=> busy && !rsp_strobe)
      else $error("placement search did not start");

   // a placement is only reported at the end of a search
   a_found_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.found |-> $past(busy))
      else $error("placement reported without a search");

endmodule

bind skyline_atlas_allocator sla_checker u_sla_checker (.*);
